/* rtl/forth_data_stack_unit_assert.svh */
// Assertion macros shared by the stack unit's RTL.
// Each one samples on aclk and is disabled while aresetn is low.
`ifndef FORTH_DATA_STACK_UNIT_ASSERT_SVH
`define FORTH_DATA_STACK_UNIT_ASSERT_SVH

// A condition that holds at every clock edge.
`define FSU_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define FSU_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define FSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fsu_pkg.sv */
package fsu_pkg;

    localparam int WORD_W = 32;

    // Operation codes carried in the op field.
    localparam logic [4:0] OP_PUSH  = 5'd0;
    localparam logic [4:0] OP_POP   = 5'd1;
    localparam logic [4:0] OP_PEEK  = 5'd2;
    localparam logic [4:0] OP_OVER  = 5'd3;
    localparam logic [4:0] OP_DUP   = 5'd4;
    localparam logic [4:0] OP_DUPNZ = 5'd5;
    localparam logic [4:0] OP_SWAP  = 5'd6;
    localparam logic [4:0] OP_ADD   = 5'd7;
    localparam logic [4:0] OP_SUB   = 5'd8;
    localparam logic [4:0] OP_MUL   = 5'd9;
    localparam logic [4:0] OP_DIV   = 5'd10;
    localparam logic [4:0] OP_MOD   = 5'd11;
    localparam logic [4:0] OP_INC   = 5'd12;
    localparam logic [4:0] OP_DEC   = 5'd13;
    localparam logic [4:0] OP_ADD4  = 5'd14;
    localparam logic [4:0] OP_SUB4  = 5'd15;
    localparam logic [4:0] OP_CLEAR = 5'd16;

    // Status codes carried in the result beat.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;
    localparam logic [1:0] ST_DIVZ  = 2'd3;

    // What a stack cell does at the next clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_ABOVE,
        CELL_FROM_BELOW,
        CELL_LOAD
    } cell_op_t;

    // Handshake state of the divider towards the controller.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* rtl/fsu_cell.sv */
module fsu_cell (
    input  logic                        aclk,
    input  fsu_pkg::cell_op_t           cmd,
    input  logic [fsu_pkg::WORD_W-1:0]  above_word,
    input  logic [fsu_pkg::WORD_W-1:0]  below_word,
    input  logic [fsu_pkg::WORD_W-1:0]  load_word,
    output logic [fsu_pkg::WORD_W-1:0]  word
);

    logic [fsu_pkg::WORD_W-1:0] word_reg;
    logic [fsu_pkg::WORD_W-1:0] word_next;

    always_comb begin
        case (cmd)
            fsu_pkg::CELL_FROM_ABOVE: word_next = above_word;
            fsu_pkg::CELL_FROM_BELOW: word_next = below_word;
            fsu_pkg::CELL_LOAD:       word_next = load_word;
            default:                  word_next = word_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

/* rtl/fsu_div.sv */
module fsu_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic                        ack,
    input  logic [fsu_pkg::WORD_W-1:0]  dividend,
    input  logic [fsu_pkg::WORD_W-1:0]  divisor,
    output fsu_pkg::div_stat_t          stat,
    output logic [fsu_pkg::WORD_W-1:0]  quotient,
    output logic [fsu_pkg::WORD_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(fsu_pkg::WORD_W);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [fsu_pkg::WORD_W-1:0]  quo_reg;
    logic [fsu_pkg::WORD_W-1:0]  rem_reg;
    logic [fsu_pkg::WORD_W-1:0]  dvs_reg;
    logic [fsu_pkg::WORD_W:0]    partial;
    logic [fsu_pkg::WORD_W:0]    diff;

    // One restoring step per cycle: shift in the next dividend bit and try
    // to subtract the divisor.
    assign partial = {rem_reg, quo_reg[fsu_pkg::WORD_W-1]};
    assign diff    = partial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                if (!diff[fsu_pkg::WORD_W]) begin
                    rem_reg <= diff[fsu_pkg::WORD_W-1:0];
                    quo_reg <= {quo_reg[fsu_pkg::WORD_W-2:0], 1'b1};
                end else begin
                    rem_reg <= partial[fsu_pkg::WORD_W-1:0];
                    quo_reg <= {quo_reg[fsu_pkg::WORD_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(fsu_pkg::WORD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            if (ack) begin
                done_reg <= 1'b0;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/forth_data_stack_unit.sv */
// Result beat: in the cycle after an input beat is accepted, except for div and mod with a
// nonzero divisor, which go through the bit-serial divider. Throughput: one operation per
// cycle while the result side keeps up; div and mod with a nonzero divisor hold the input side
// for their whole division, since the divider handles one quotient bit a cycle.
// Reset (aresetn low, synchronous) empties the stack and drops any pending result beat; the
// stack cells themselves are not cleared, as only words below the depth are ever read.
module forth_data_stack_unit #(
    parameter int DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input beats: one stack operation each.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [4:0] op, [36:5] push_value, [39:37] zero
    // Result beats: exactly one per operation.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [31:0] result_word, [38:32] stack_depth,
                                   // [40:39] status, [47:41] zero
);

    `include "forth_data_stack_unit_assert.svh"

    // The depth register must hold every value from empty up to a full stack.
    localparam int DW = $clog2(DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [DW-1:0]               depth_reg;
    logic [DW-1:0]               depth_next;
    logic                        mod_sel_reg;
    logic                        m_tvalid_reg;
    logic [47:0]                 m_tdata_reg;

    logic [4:0]                  op;
    logic [fsu_pkg::WORD_W-1:0]  push_value;
    logic                        out_free;
    logic                        accept;

    // The stack is a row of cells; cell 0 is the top of stack.
    logic [fsu_pkg::WORD_W-1:0]  cell_word [DEPTH];
    fsu_pkg::cell_op_t           cell_cmd  [DEPTH];
    logic [fsu_pkg::WORD_W-1:0]  top_word;
    logic [fsu_pkg::WORD_W-1:0]  second_word;

    logic                        shift_dn;
    logic                        shift_up;
    logic                        load_top;
    logic                        load_second;
    logic [fsu_pkg::WORD_W-1:0]  top_val;
    logic [fsu_pkg::WORD_W-1:0]  res_word;
    logic [1:0]                  res_status;
    logic                        out_load;
    logic                        div_start;
    logic                        div_ack;
    logic                        under;
    logic                        grows;
    logic                        full;
    logic [fsu_pkg::WORD_W-1:0]  mul_word;

    fsu_pkg::div_stat_t          div_stat;
    logic [fsu_pkg::WORD_W-1:0]  div_quo;
    logic [fsu_pkg::WORD_W-1:0]  div_rem;

    assign op          = s_tdata[4:0];
    assign push_value  = s_tdata[36:5];
    assign top_word    = cell_word[0];
    assign second_word = cell_word[1];
    assign full        = (depth_reg == DW'(DEPTH));
    assign mul_word    = fsu_pkg::WORD_W'(top_word * second_word);

    // A new operation is taken only while no division is running and the
    // result register is empty or being emptied in this cycle.
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // Underflow check: how many words the operation needs on the stack.
    always_comb begin
        case (op)
            fsu_pkg::OP_POP, fsu_pkg::OP_PEEK, fsu_pkg::OP_DUP, fsu_pkg::OP_DUPNZ,
            fsu_pkg::OP_INC, fsu_pkg::OP_DEC, fsu_pkg::OP_ADD4, fsu_pkg::OP_SUB4:
                under = (depth_reg == '0);
            fsu_pkg::OP_OVER, fsu_pkg::OP_SWAP, fsu_pkg::OP_ADD, fsu_pkg::OP_SUB,
            fsu_pkg::OP_MUL, fsu_pkg::OP_DIV, fsu_pkg::OP_MOD:
                under = (depth_reg < DW'(2));
            default:
                under = 1'b0;
        endcase
    end

    // Overflow check: push and dup always grow the stack, dupnz only on a
    // nonzero top word.
    always_comb begin
        case (op)
            fsu_pkg::OP_PUSH, fsu_pkg::OP_DUP: grows = 1'b1;
            fsu_pkg::OP_DUPNZ:                 grows = (top_word != '0);
            default:                           grows = 1'b0;
        endcase
    end

    // Operation decode. Everything except a real division settles in the
    // cycle of acceptance: the cells get their shift or load command, the
    // depth its new value and the result register its beat.
    always_comb begin
        shift_dn    = 1'b0;
        shift_up    = 1'b0;
        load_top    = 1'b0;
        load_second = 1'b0;
        top_val     = top_word;
        depth_next  = depth_reg;
        res_word    = (depth_reg != '0) ? top_word : '0;
        res_status  = fsu_pkg::ST_OK;
        out_load    = 1'b0;
        div_start   = 1'b0;
        div_ack     = 1'b0;
        state_next  = state_reg;

        if (state_reg == ST_DIV) begin
            // The divider holds its answer until the result register is free.
            if (div_stat.done && out_free) begin
                shift_up   = 1'b1;
                load_top   = 1'b1;
                top_val    = mod_sel_reg ? div_rem : div_quo;
                depth_next = depth_reg - DW'(1);
                res_word   = top_val;
                out_load   = 1'b1;
                div_ack    = 1'b1;
                state_next = ST_IDLE;
            end
        end else if (accept) begin
            out_load = 1'b1;
            if (under) begin
                res_status = fsu_pkg::ST_UNDER;
            end else if (grows && full) begin
                res_status = fsu_pkg::ST_OVER;
            end else begin
                case (op)
                    fsu_pkg::OP_PUSH: begin
                        shift_dn   = 1'b1;
                        load_top   = 1'b1;
                        top_val    = push_value;
                        depth_next = depth_reg + DW'(1);
                        res_word   = push_value;
                    end
                    fsu_pkg::OP_POP: begin
                        shift_up   = 1'b1;
                        depth_next = depth_reg - DW'(1);
                        res_word   = top_word;
                    end
                    fsu_pkg::OP_PEEK: begin
                        res_word = top_word;
                    end
                    fsu_pkg::OP_OVER: begin
                        res_word = second_word;
                    end
                    fsu_pkg::OP_DUP, fsu_pkg::OP_DUPNZ: begin
                        // Dupnz on a zero top leaves the stack as it is.
                        if (grows) begin
                            shift_dn   = 1'b1;
                            load_top   = 1'b1;
                            depth_next = depth_reg + DW'(1);
                        end
                        res_word = top_word;
                    end
                    fsu_pkg::OP_SWAP: begin
                        load_top    = 1'b1;
                        load_second = 1'b1;
                        top_val     = second_word;
                        res_word    = second_word;
                    end
                    fsu_pkg::OP_ADD, fsu_pkg::OP_SUB, fsu_pkg::OP_MUL: begin
                        shift_up   = 1'b1;
                        load_top   = 1'b1;
                        depth_next = depth_reg - DW'(1);
                        if (op == fsu_pkg::OP_ADD) begin
                            top_val = top_word + second_word;
                        end else if (op == fsu_pkg::OP_SUB) begin
                            top_val = top_word - second_word;
                        end else begin
                            top_val = mul_word;
                        end
                        res_word = top_val;
                    end
                    fsu_pkg::OP_DIV, fsu_pkg::OP_MOD: begin
                        if (second_word == '0) begin
                            // Division by zero still pops: quotient all ones,
                            // remainder the dividend.
                            shift_up   = 1'b1;
                            load_top   = 1'b1;
                            top_val    = (op == fsu_pkg::OP_DIV) ? '1 : top_word;
                            depth_next = depth_reg - DW'(1);
                            res_word   = top_val;
                            res_status = fsu_pkg::ST_DIVZ;
                        end else begin
                            out_load   = 1'b0;
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    fsu_pkg::OP_INC, fsu_pkg::OP_DEC, fsu_pkg::OP_ADD4, fsu_pkg::OP_SUB4: begin
                        load_top = 1'b1;
                        case (op)
                            fsu_pkg::OP_INC:  top_val = top_word + 32'd1;
                            fsu_pkg::OP_DEC:  top_val = top_word - 32'd1;
                            fsu_pkg::OP_ADD4: top_val = top_word + 32'd4;
                            default:          top_val = top_word - 32'd4;
                        endcase
                        res_word = top_val;
                    end
                    fsu_pkg::OP_CLEAR: begin
                        depth_next = '0;
                        res_word   = '0;
                    end
                    default: begin
                        // Unassigned codes leave the stack untouched.
                    end
                endcase
            end
        end
    end

    // Commands for the row of cells. A push moves every word one cell down,
    // a pop one cell up; cell 0 and, for swap, cell 1 are loaded directly.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if ((i == 0 && load_top) || (i == 1 && load_second)) begin
                cell_cmd[i] = fsu_pkg::CELL_LOAD;
            end else if (shift_dn && i != 0) begin
                cell_cmd[i] = fsu_pkg::CELL_FROM_ABOVE;
            end else if (shift_up) begin
                cell_cmd[i] = fsu_pkg::CELL_FROM_BELOW;
            end else begin
                cell_cmd[i] = fsu_pkg::CELL_HOLD;
            end
        end
    end

    generate
        for (genvar g = 0; g < DEPTH; g++) begin : g_cell
            logic [fsu_pkg::WORD_W-1:0] above_w;
            logic [fsu_pkg::WORD_W-1:0] below_w;
            logic [fsu_pkg::WORD_W-1:0] load_w;

            if (g == 0) begin : g_top
                assign above_w = '0;
                assign load_w  = top_val;
            end else if (g == 1) begin : g_second
                assign above_w = cell_word[0];
                assign load_w  = top_word;
            end else begin : g_inner
                assign above_w = cell_word[g-1];
                assign load_w  = '0;
            end

            if (g == DEPTH - 1) begin : g_bottom
                assign below_w = '0;
            end else begin : g_link
                assign below_w = cell_word[g+1];
            end

            fsu_cell u_cell (
                .aclk       (aclk),
                .cmd        (cell_cmd[g]),
                .above_word (above_w),
                .below_word (below_w),
                .load_word  (load_w),
                .word       (cell_word[g])
            );
        end
    endgenerate

    // Division takes the popped top word as dividend and the word below as
    // divisor.
    fsu_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .ack       (div_ack),
        .dividend  (top_word),
        .divisor   (second_word),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Control state, depth and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            depth_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            if (div_start) begin
                mod_sel_reg <= (op == fsu_pkg::OP_MOD);
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {7'd0, res_status, 7'(depth_next), res_word};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `FSU_ASSERT_ALWAYS(a_depth_in_range, depth_reg <= DW'(DEPTH), "stack depth beyond capacity")
    `FSU_ASSERT_IMPLIES(a_div_idle, state_reg == ST_IDLE, !div_stat.busy && !div_stat.done, "divider active outside division")
    `FSU_ASSERT_IMPLIES(a_over_full, m_tvalid_reg && m_tdata_reg[40:39] == fsu_pkg::ST_OVER, m_tdata_reg[38:32] == 7'(DEPTH), "overflow reported on a stack that is not full")
    `FSU_ASSERT_NEXT(a_clear_empties, accept && op == fsu_pkg::OP_CLEAR, depth_reg == '0 && m_tvalid_reg, "clear did not empty the stack")

endmodule

/* tb/forth_data_stack_unit_checker.sv */
// Watches both channels of the stack unit, keeps its own copy of the stack,
// and compares every result beat against the oldest predicted one.
module forth_data_stack_unit_checker #(
    parameter int STACK_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // [4:0] op, [36:5] push_value, [39:37] zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // [31:0] result_word, [38:32] stack_depth,
                                   // [40:39] status, [47:41] zero
    output int          fail_count,
    output int          pending_count
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] word;
        logic [6:0]  depth;
        logic [1:0]  status;
    } stack_result_t;

    logic [31:0]   model_words [STACK_DEPTH];
    int            model_depth = 0;
    stack_result_t awaited_results [$];
    int            mismatch_total = 0;
    int            awaited_total = 0;

    assign fail_count    = mismatch_total;
    assign pending_count = awaited_total;

    // Applies one operation to the model stack and returns the beat it should cause.
    function automatic stack_result_t apply_stack_op(input logic [4:0] op,
                                                     input logic [31:0] push_word);
        stack_result_t res;
        logic [31:0]   top_w;
        logic [31:0]   next_w;
        logic [31:0]   answer;
        int            need;
        bit            grows;
        bit            word_set;
        need     = 0;
        grows    = 1'b0;
        word_set = 1'b0;
        res.word   = '0;
        res.status = fsu_pkg::ST_OK;
        case (op)
            fsu_pkg::OP_PUSH: grows = 1'b1;
            fsu_pkg::OP_POP, fsu_pkg::OP_PEEK, fsu_pkg::OP_DUP, fsu_pkg::OP_DUPNZ,
            fsu_pkg::OP_INC, fsu_pkg::OP_DEC, fsu_pkg::OP_ADD4, fsu_pkg::OP_SUB4: need = 1;
            fsu_pkg::OP_OVER, fsu_pkg::OP_SWAP, fsu_pkg::OP_ADD, fsu_pkg::OP_SUB,
            fsu_pkg::OP_MUL, fsu_pkg::OP_DIV, fsu_pkg::OP_MOD: need = 2;
            default: ;
        endcase
        if (model_depth < need) begin
            res.status = fsu_pkg::ST_UNDER;
        end else begin
            if (op == fsu_pkg::OP_DUP) grows = 1'b1;
            if (op == fsu_pkg::OP_DUPNZ && model_words[model_depth - 1] != '0) grows = 1'b1;
            if (grows && model_depth >= STACK_DEPTH) begin
                res.status = fsu_pkg::ST_OVER;
            end else begin
                case (op)
                    fsu_pkg::OP_PUSH: begin
                        model_words[model_depth] = push_word;
                        model_depth++;
                    end
                    fsu_pkg::OP_POP: begin
                        res.word = model_words[model_depth - 1];
                        word_set = 1'b1;
                        model_depth--;
                    end
                    fsu_pkg::OP_PEEK: begin
                        res.word = model_words[model_depth - 1];
                        word_set = 1'b1;
                    end
                    fsu_pkg::OP_OVER: begin
                        res.word = model_words[model_depth - 2];
                        word_set = 1'b1;
                    end
                    fsu_pkg::OP_DUP, fsu_pkg::OP_DUPNZ: begin
                        if (grows) begin
                            model_words[model_depth] = model_words[model_depth - 1];
                            model_depth++;
                        end
                    end
                    fsu_pkg::OP_SWAP: begin
                        top_w = model_words[model_depth - 1];
                        model_words[model_depth - 1] = model_words[model_depth - 2];
                        model_words[model_depth - 2] = top_w;
                    end
                    fsu_pkg::OP_INC:
                        model_words[model_depth - 1] = model_words[model_depth - 1] + 32'd1;
                    fsu_pkg::OP_DEC:
                        model_words[model_depth - 1] = model_words[model_depth - 1] - 32'd1;
                    fsu_pkg::OP_ADD4:
                        model_words[model_depth - 1] = model_words[model_depth - 1] + 32'd4;
                    fsu_pkg::OP_SUB4:
                        model_words[model_depth - 1] = model_words[model_depth - 1] - 32'd4;
                    fsu_pkg::OP_CLEAR: model_depth = 0;
                    fsu_pkg::OP_ADD, fsu_pkg::OP_SUB, fsu_pkg::OP_MUL,
                    fsu_pkg::OP_DIV, fsu_pkg::OP_MOD: begin
                        // The popped top is the left operand.
                        top_w = model_words[model_depth - 1];
                        model_depth--;
                        next_w = model_words[model_depth - 1];
                        case (op)
                            fsu_pkg::OP_ADD: answer = top_w + next_w;
                            fsu_pkg::OP_SUB: answer = top_w - next_w;
                            fsu_pkg::OP_MUL: answer = top_w * next_w;
                            default: begin
                                if (next_w == '0) begin
                                    res.status = fsu_pkg::ST_DIVZ;
                                    answer = (op == fsu_pkg::OP_DIV) ? 32'hFFFF_FFFF : top_w;
                                end else begin
                                    answer = (op == fsu_pkg::OP_DIV) ? top_w / next_w
                                                                     : top_w % next_w;
                                end
                            end
                        endcase
                        model_words[model_depth - 1] = answer;
                    end
                    default: ;
                endcase
            end
        end
        if (!word_set) res.word = (model_depth > 0) ? model_words[model_depth - 1] : '0;
        res.depth = 7'(model_depth);
        return res;
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_total++;
        if (mismatch_total <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
    endtask

    always @(posedge aclk) begin
        stack_result_t want;
        if (!aresetn) begin
            model_depth = 0;
            awaited_results.delete();
        end else begin
            // A result beat always belongs to an operation accepted at an earlier edge.
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= 10)
                        $display("%0t: result beat %h with none outstanding",
                                 $realtime, m_tdata);
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tdata[31:0] !== want.word)
                        note_mismatch("result_word", want.word, m_tdata[31:0]);
                    if (m_tdata[38:32] !== want.depth)
                        note_mismatch("stack_depth", 32'(want.depth), 32'(m_tdata[38:32]));
                    if (m_tdata[40:39] !== want.status)
                        note_mismatch("status", 32'(want.status), 32'(m_tdata[40:39]));
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(apply_stack_op(s_tdata[4:0], s_tdata[36:5]));
        end
        awaited_total = awaited_results.size();
    end

endmodule

/* tb/forth_data_stack_unit_test.sv */
// Top of the stack unit's testbench. It resets the block once, sends a short
// directed run of operations followed by random segments, throttles both
// channels, and gives the verdict from the checker's failure count.
module forth_data_stack_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         STACK_DEPTH   = 64;
    localparam int         RANDOM_BEATS  = 1600;
    localparam logic [4:0] OP_UNDEF_LAST = 5'd31;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // [4:0] op, [36:5] push_value, [39:37] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // [31:0] result_word, [38:32] stack_depth,
                                 // [40:39] status, [47:41] zero
    int          fail_count;
    int          pending_count;

    int          ops_sent = 0;
    int          results_taken = 0;
    bit          sender_burst = 1'b0;

    always #5 aclk = ~aclk;

    forth_data_stack_unit #(
        .DEPTH(STACK_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    forth_data_stack_unit_checker #(
        .STACK_DEPTH(STACK_DEPTH)
    ) stack_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Push words lean towards zero, all ones and small values, so that the
    // division paths see zero divisors and non-trivial quotients alike.
    function automatic logic [31:0] random_push_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return '0;
        if (r < 25) return 32'hFFFF_FFFF;
        if (r < 50) return $urandom_range(0, 15);
        return $urandom;
    endfunction

    // Picks an operation; push_weight sets how fast the stack tends to grow.
    function automatic logic [4:0] pick_op(input int push_weight);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_weight) return fsu_pkg::OP_PUSH;
        if (r < push_weight + 1) return fsu_pkg::OP_CLEAR;
        if (r < push_weight + 3)
            return 5'($urandom_range(fsu_pkg::OP_CLEAR + 1, OP_UNDEF_LAST));
        case ($urandom_range(0, 14))
            0:       return fsu_pkg::OP_POP;
            1:       return fsu_pkg::OP_PEEK;
            2:       return fsu_pkg::OP_OVER;
            3:       return fsu_pkg::OP_DUP;
            4:       return fsu_pkg::OP_DUPNZ;
            5:       return fsu_pkg::OP_SWAP;
            6:       return fsu_pkg::OP_ADD;
            7:       return fsu_pkg::OP_SUB;
            8:       return fsu_pkg::OP_MUL;
            9:       return fsu_pkg::OP_DIV;
            10:      return fsu_pkg::OP_MOD;
            11:      return fsu_pkg::OP_INC;
            12:      return fsu_pkg::OP_DEC;
            13:      return fsu_pkg::OP_ADD4;
            default: return fsu_pkg::OP_SUB4;
        endcase
    endfunction

    // Offers one beat at the falling edge and holds it until the block takes it
    // at a rising edge. A following beat with no gap keeps tvalid high, so it is
    // only ever assigned once per step.
    task automatic send_op(input logic [4:0] op, input logic [31:0] value);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, value, op};
        do @(posedge aclk); while (!s_tready);
        ops_sent++;
        gap = sender_burst ? 0 : idle_length();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= {3'b000, 32'($urandom), 5'($urandom)};
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // Stimulus and verdict.
    initial begin
        int push_weight;
        int seg_len;
        int profile;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: underflow on an empty stack, wrap-round at the word
        // boundary, dupnz on zero and nonzero tops, zero divisors for both div
        // and mod, ordinary division, and an undefined operation code.
        send_op(fsu_pkg::OP_POP,   32'h0);
        send_op(fsu_pkg::OP_OVER,  32'h0);
        send_op(fsu_pkg::OP_ADD,   32'h0);
        send_op(fsu_pkg::OP_PUSH,  32'hFFFF_FFFF);
        send_op(fsu_pkg::OP_INC,   32'h0);
        send_op(fsu_pkg::OP_DUPNZ, 32'h0);
        send_op(fsu_pkg::OP_DEC,   32'h0);
        send_op(fsu_pkg::OP_DUPNZ, 32'h0);
        send_op(fsu_pkg::OP_ADD,   32'h0);
        send_op(fsu_pkg::OP_SWAP,  32'h0);
        send_op(fsu_pkg::OP_PUSH,  32'h0);
        send_op(fsu_pkg::OP_PUSH,  32'h7);
        send_op(fsu_pkg::OP_DIV,   32'h0);
        send_op(fsu_pkg::OP_PUSH,  32'h0);
        send_op(fsu_pkg::OP_SWAP,  32'h0);
        send_op(fsu_pkg::OP_MOD,   32'h0);
        send_op(fsu_pkg::OP_OVER,  32'h0);
        send_op(fsu_pkg::OP_SUB,   32'h0);
        send_op(fsu_pkg::OP_PUSH,  32'h10);
        send_op(fsu_pkg::OP_MUL,   32'h0);
        send_op(fsu_pkg::OP_PUSH,  32'd100);
        send_op(fsu_pkg::OP_DIV,   32'h0);
        send_op(fsu_pkg::OP_PUSH,  32'd20);
        send_op(fsu_pkg::OP_MOD,   32'h0);
        send_op(fsu_pkg::OP_ADD4,  32'h0);
        send_op(fsu_pkg::OP_SUB4,  32'h0);
        send_op(fsu_pkg::OP_DUP,   32'h0);
        send_op(OP_UNDEF_LAST,     32'hFFFF_FFFF);
        send_op(fsu_pkg::OP_CLEAR, 32'h0);
        send_op(fsu_pkg::OP_PEEK,  32'h0);

        // Random part, in segments that grow, balance or drain the stack, with
        // an occasional fill right up to the top so that overflow is exercised.
        while (ops_sent < RANDOM_BEATS) begin
            profile      = $urandom_range(0, 9);
            seg_len      = $urandom_range(20, 80);
            sender_burst = ($urandom_range(0, 3) == 0);
            if (profile == 0) begin
                repeat (STACK_DEPTH + 6) send_op(fsu_pkg::OP_PUSH, random_push_value());
                send_op(fsu_pkg::OP_DUP,   32'h0);
                send_op(fsu_pkg::OP_DUPNZ, 32'h0);
                repeat (seg_len / 4) send_op(pick_op(40), random_push_value());
            end else begin
                if (profile <= 3)      push_weight = 55;
                else if (profile <= 6) push_weight = 35;
                else                   push_weight = 15;
                repeat (seg_len) send_op(pick_op(push_weight), random_push_value());
            end
        end
        sender_burst = 1'b0;

        @(negedge aclk);
        s_tvalid <= 1'b0;
        // Let every outstanding result arrive, then allow for a full division's
        // latency in case anything stray is still on its way out.
        while (pending_count != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) results_taken++;
    end

    // Receiver: random back-pressure with stretches of none, and one long
    // hold-off while the sender keeps offering beats, so that the block backs
    // up and has to stall its input side.
    initial begin
        int  ready_gap;
        int  burst_left;
        bit  long_hold_done;
        int  r;
        ready_gap      = 0;
        burst_left     = 0;
        long_hold_done = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!long_hold_done && results_taken >= 400) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
            end else if (burst_left > 0) begin
                m_tready <= 1'b1;
                burst_left--;
            end else if (ready_gap > 0) begin
                m_tready <= 1'b0;
                ready_gap--;
            end else begin
                m_tready <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 5)       burst_left = $urandom_range(50, 200);
                else if (r < 30) ready_gap = idle_length();
            end
        end
    end

    // Watchdog: far beyond the slowest correct run, even with every division
    // taking its full time and both sides idling at their longest.
    initial begin
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
